[design/fpl_pkg.sv]
`timescale 1ns / 1ps

package fpl_pkg;

    // field widths
    localparam int DIM_W      = 14;
    localparam int ROWS_W     = 15;
    localparam int FMT_W      = 4;
    localparam int ADDR_W     = 32;
    localparam int ALIGN_W    = 13;
    localparam int RAW_W      = 16;
    localparam int NUM_W      = 17;
    localparam int PROD_W     = 32;
    localparam int OFF_W      = 34;
    localparam int TOT_W      = 31;
    localparam int IDX_W      = 2;

    // stream packing
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 4;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 3;

    // alignment remainder unit: bits resolved per stage and stage count
    localparam int BPS        = 2;
    localparam int DIV_STAGES = (NUM_W + BPS - 1) / BPS;
    localparam int DIV_PAD_W  = DIV_STAGES * BPS;
    localparam int DIV_LAT    = DIV_STAGES + 1;

    localparam logic [OFF_W-1:0] TOT_MAX = OFF_W'(34'h0_7FFF_FFFF);

    typedef enum logic [FMT_W-1:0] {
        FMT_YUV420P    = 4'd0,
        FMT_YUV420P_HI = 4'd1,
        FMT_YUV422P    = 4'd2,
        FMT_YUV422P_HI = 4'd3,
        FMT_YUV444P    = 4'd4,
        FMT_YUV444P_HI = 4'd5,
        FMT_NV12       = 4'd6,
        FMT_P016       = 4'd7,
        FMT_NV16       = 4'd8,
        FMT_NV24       = 4'd9,
        FMT_GRAY8      = 4'd10,
        FMT_GRAY16     = 4'd11,
        FMT_GRAYF32    = 4'd12,
        FMT_RGB24      = 4'd13,
        FMT_RGB32      = 4'd14,
        FMT_BAD        = 4'd15
    } t_fmt;

    // frame data that rides alongside the alignment unit
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [ROWS_W-1:0] rows0;
        logic [ROWS_W-1:0] rows1;
        logic [IDX_W-1:0]  last_idx;
        logic              err;
    } t_side;

    // one finished plane descriptor
    typedef struct packed {
        logic [NUM_W-1:0]  stride;
        logic [ROWS_W-1:0] rows;
        logic [ADDR_W-1:0] addr;
        logic [TOT_W-1:0]  total;
    } t_plane;

    // one restoring step of the remainder: shift in a bit, subtract if it fits
    function automatic logic [ALIGN_W-1:0] rem_step(input logic [ALIGN_W-1:0] rem,
                                                    input logic b,
                                                    input logic [ALIGN_W-1:0] d);
        logic [ALIGN_W:0] t;
        logic [ALIGN_W:0] diff;
        t    = {rem, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return diff[ALIGN_W-1:0];
        end
        return t[ALIGN_W-1:0];
    endfunction

endpackage

[design/fpl_align_div.sv]
`timescale 1ns / 1ps

module fpl_align_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [fpl_pkg::NUM_W-1:0]    i_num,
    input  logic [fpl_pkg::ALIGN_W-1:0]  i_div,
    output logic [fpl_pkg::NUM_W-1:0]    o_aligned
);
    import fpl_pkg::*;

    logic [NUM_W-1:0]   r_num [DIV_STAGES];
    logic [ALIGN_W-1:0] r_rem [DIV_STAGES];
    logic [ALIGN_W-1:0] n_rem [DIV_STAGES];
    logic [NUM_W-1:0]   r_out;

    // remainder stages, most significant bits first
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [NUM_W-1:0]     num_in;
        logic [ALIGN_W-1:0]   rem_in;
        logic [DIV_PAD_W-1:0] num_pad;

        if (k == 0) begin : g_first
            assign num_in = i_num;
            assign rem_in = '0;
        end else begin : g_next
            assign num_in = r_num[k-1];
            assign rem_in = r_rem[k-1];
        end

        assign num_pad = DIV_PAD_W'(num_in);

        always_comb begin
            logic [BPS-1:0]     chunk;
            logic [ALIGN_W-1:0] rem_v;
            chunk = num_pad[DIV_PAD_W-1-k*BPS -: BPS];
            rem_v = rem_in;
            for (int j = 0; j < BPS; j++) begin
                rem_v = rem_step(rem_v, chunk[BPS-1], i_div);
                chunk = chunk << 1;
            end
            n_rem[k] = rem_v;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= num_in;
                r_rem[k] <= n_rem[k];
            end
        end
    end

    // rounded-up stride is the biased value less its remainder
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= r_num[DIV_STAGES-1] - NUM_W'(r_rem[DIV_STAGES-1]);
        end
    end

    assign o_aligned = r_out;

endmodule

[design/frame_plane_layout_unit.sv]
`timescale 1ns / 1ps

// Planar frame layout unit. Each frame request (width, height, format class
// in tuser, base address) yields one result per plane, 1 to 3 of them, or a
// single error result for an unsupported class; tlast marks the final one.
// A request enters a pipeline of DIV_LAT + 5 register stages (15 with the
// default settings): input decode, a ten-stage alignment unit (nine remainder
// stages that resolve two bits each, then the round-up subtraction), a
// multiply stage, an offset stage, a frame holding stage and the result
// register. A new request is taken every cycle while the result side keeps
// up and no earlier frame still has planes to hand out; one result port
// serves all planes, so a frame of two or three planes holds the request
// side until its last plane goes. Strides are aligned to the stride_alignment
// register (0 acts as 1); write it only while no request is in flight.
module frame_plane_layout_unit #(
    parameter int unsigned MAX_DIM = 16384
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // stride alignment register
    input  logic                           i_cfg_wen,
    input  logic [fpl_pkg::ALIGN_W-1:0]    i_cfg_wdata,
    // request side
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // image_width[13:0], image_height[27:14], base_address[59:28], zero pad
    input  logic [fpl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // format_class[3:0]
    input  logic [fpl_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // result side
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // line_stride[16:0], plane_rows[31:17], plane_address[63:32],
    // frame_bytes[94:64], zero pad
    output logic [fpl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    // plane_index[1:0], format_error[2]
    output logic [fpl_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import fpl_pkg::*;

    localparam int unsigned DIM_FULL = (1 << DIM_W) - 1;
    localparam int unsigned CAP_I    = (MAX_DIM < DIM_FULL) ? MAX_DIM : DIM_FULL;
    localparam logic [DIM_W-1:0] DIM_CAP = CAP_I[DIM_W-1:0];

    // configuration
    logic [ALIGN_W-1:0] r_align;
    logic [ALIGN_W-1:0] div_val;
    logic [ALIGN_W-1:0] align_m1;

    // handshake control
    logic pipe_en;
    logic o_load;
    logic f_give;
    logic f_last;

    // request decode
    t_fmt              fmt;
    logic [DIM_W-1:0]  w_c;
    logic [DIM_W-1:0]  h_c;
    logic [ROWS_W-1:0] we;
    logic [ROWS_W-1:0] he;
    logic [ROWS_W-1:0] h15;
    logic [RAW_W-1:0]  w16;
    logic [RAW_W-1:0]  we16;
    logic [RAW_W-1:0]  st0;
    logic [RAW_W-1:0]  st1;
    t_side             n_side;

    // stage registers
    logic             r_a_valid;
    logic [NUM_W-1:0] r_a_num0;
    logic [NUM_W-1:0] r_a_num1;
    t_side            r_a_side;

    logic             r_d_valid [DIV_LAT];
    t_side            r_d_side  [DIV_LAT];
    logic [NUM_W-1:0] div_s0;
    logic [NUM_W-1:0] div_s1;

    logic              r_m_valid;
    logic [PROD_W-1:0] r_m_p0;
    logic [PROD_W-1:0] r_m_p1;
    logic [NUM_W-1:0]  r_m_s0;
    logic [NUM_W-1:0]  r_m_s1;
    t_side             r_m_side;

    logic              r_s_valid;
    logic [PROD_W-1:0] r_s_off1;
    logic [PROD_W:0]   r_s_off2;
    logic [OFF_W-1:0]  r_s_off3;
    logic [NUM_W-1:0]  r_s_s0;
    logic [NUM_W-1:0]  r_s_s1;
    t_side             r_s_side;

    logic             r_f_valid;
    logic [IDX_W-1:0] r_f_idx;
    logic [IDX_W-1:0] r_f_last_idx;
    logic             r_f_err;
    t_plane           r_f_plane0;
    t_plane           r_f_plane1;
    t_plane           r_f_plane2;
    t_plane           n_f_plane0;
    t_plane           n_f_plane1;
    t_plane           n_f_plane2;

    logic                  r_o_valid;
    logic [OUT_DATA_W-1:0] r_o_data;
    logic [OUT_USER_W-1:0] r_o_user;
    logic                  r_o_last;
    logic [OUT_DATA_W-1:0] n_o_data;
    logic [OUT_USER_W-1:0] n_o_user;
    t_plane                sel_plane;

    function automatic logic [TOT_W-1:0] sat_total(input logic [OFF_W-1:0] v);
        if (v > TOT_MAX) begin
            return TOT_MAX[TOT_W-1:0];
        end
        return v[TOT_W-1:0];
    endfunction

    // alignment register, zero treated as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align <= ALIGN_W'(1);
        end else if (i_cfg_wen) begin
            r_align <= i_cfg_wdata;
        end
    end

    assign div_val  = (r_align == '0) ? ALIGN_W'(1) : r_align;
    assign align_m1 = div_val - ALIGN_W'(1);

    // flow control: frame stage frees after handing over its last plane
    assign o_load        = !r_o_valid || m_axis_tready;
    assign f_last        = r_f_err || (r_f_idx == r_f_last_idx);
    assign f_give        = r_f_valid && o_load;
    assign pipe_en       = !r_f_valid || (f_give && f_last);
    assign s_axis_tready = pipe_en;

    // decode dimensions and raw strides
    always_comb begin
        fmt  = t_fmt'(s_axis_tuser[FMT_W-1:0]);
        w_c  = (s_axis_tdata[DIM_W-1:0] > DIM_CAP) ? DIM_CAP : s_axis_tdata[DIM_W-1:0];
        h_c  = (s_axis_tdata[2*DIM_W-1:DIM_W] > DIM_CAP) ? DIM_CAP
                                                          : s_axis_tdata[2*DIM_W-1:DIM_W];
        we   = (ROWS_W'(w_c) + ROWS_W'(1)) & ~ROWS_W'(1);
        he   = (ROWS_W'(h_c) + ROWS_W'(1)) & ~ROWS_W'(1);
        h15  = ROWS_W'(h_c);
        w16  = RAW_W'(w_c);
        we16 = RAW_W'(we);

        st0    = '0;
        st1    = '0;
        n_side = '0;
        n_side.base = s_axis_tdata[2*DIM_W+ADDR_W-1:2*DIM_W];

        case (fmt) inside
            FMT_YUV420P: begin
                st0 = we16;        st1 = we16 >> 1;
                n_side.rows0 = he; n_side.rows1 = he >> 1;
                n_side.last_idx = IDX_W'(2);
            end
            FMT_YUV420P_HI: begin
                st0 = we16 << 1;   st1 = we16;
                n_side.rows0 = he; n_side.rows1 = he >> 1;
                n_side.last_idx = IDX_W'(2);
            end
            FMT_YUV422P: begin
                st0 = we16;         st1 = we16 >> 1;
                n_side.rows0 = h15; n_side.rows1 = h15;
                n_side.last_idx = IDX_W'(2);
            end
            FMT_YUV422P_HI: begin
                st0 = we16 << 1;    st1 = we16;
                n_side.rows0 = h15; n_side.rows1 = h15;
                n_side.last_idx = IDX_W'(2);
            end
            FMT_YUV444P: begin
                st0 = w16;          st1 = w16;
                n_side.rows0 = h15; n_side.rows1 = h15;
                n_side.last_idx = IDX_W'(2);
            end
            FMT_YUV444P_HI: begin
                st0 = w16 << 1;     st1 = w16 << 1;
                n_side.rows0 = h15; n_side.rows1 = h15;
                n_side.last_idx = IDX_W'(2);
            end
            FMT_NV12: begin
                st0 = we16;        st1 = we16;
                n_side.rows0 = he; n_side.rows1 = he >> 1;
                n_side.last_idx = IDX_W'(1);
            end
            FMT_P016: begin
                st0 = we16 << 1;   st1 = we16 << 1;
                n_side.rows0 = he; n_side.rows1 = he >> 1;
                n_side.last_idx = IDX_W'(1);
            end
            FMT_NV16: begin
                st0 = we16;        st1 = we16;
                n_side.rows0 = he; n_side.rows1 = he;
                n_side.last_idx = IDX_W'(1);
            end
            FMT_NV24: begin
                // interleaved full-resolution chroma: two bytes per pixel
                st0 = we16;        st1 = we16 << 1;
                n_side.rows0 = he; n_side.rows1 = he;
                n_side.last_idx = IDX_W'(1);
            end
            FMT_GRAY8: begin
                st0 = w16;          n_side.rows0 = h15;
            end
            FMT_GRAY16: begin
                st0 = w16 << 1;     n_side.rows0 = h15;
            end
            FMT_GRAYF32, FMT_RGB32: begin
                st0 = w16 << 2;     n_side.rows0 = h15;
            end
            FMT_RGB24: begin
                st0 = w16 + (w16 << 1);
                n_side.rows0 = h15;
            end
            default: begin
                n_side.err = 1'b1;
            end
        endcase
    end

    // input stage: bias strides for round-up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (pipe_en) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_a_num0 <= NUM_W'(st0) + NUM_W'(align_m1);
            r_a_num1 <= NUM_W'(st1) + NUM_W'(align_m1);
            r_a_side <= n_side;
        end
    end

    // alignment lanes: luma stride and chroma stride
    fpl_align_div u_div0 (
        .i_clk     (i_clk),
        .i_en      (pipe_en),
        .i_num     (r_a_num0),
        .i_div     (div_val),
        .o_aligned (div_s0)
    );

    fpl_align_div u_div1 (
        .i_clk     (i_clk),
        .i_en      (pipe_en),
        .i_num     (r_a_num1),
        .i_div     (div_val),
        .o_aligned (div_s1)
    );

    // side data delay matched to the alignment lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_d_valid[k] <= 1'b0;
            end
        end else if (pipe_en) begin
            r_d_valid[0] <= r_a_valid;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_d_valid[k] <= r_d_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_d_side[0] <= r_a_side;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_d_side[k] <= r_d_side[k-1];
            end
        end
    end

    // plane sizes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (pipe_en) begin
            r_m_valid <= r_d_valid[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_m_p0   <= PROD_W'(div_s0) * PROD_W'(r_d_side[DIV_LAT-1].rows0);
            r_m_p1   <= PROD_W'(div_s1) * PROD_W'(r_d_side[DIV_LAT-1].rows1);
            r_m_s0   <= div_s0;
            r_m_s1   <= div_s1;
            r_m_side <= r_d_side[DIV_LAT-1];
        end
    end

    // running offsets; planes one and two share size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (pipe_en) begin
            r_s_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s_off1 <= r_m_p0;
            r_s_off2 <= (PROD_W+1)'(r_m_p0) + (PROD_W+1)'(r_m_p1);
            r_s_off3 <= OFF_W'(r_m_p0) + OFF_W'({r_m_p1, 1'b0});
            r_s_s0   <= r_m_s0;
            r_s_s1   <= r_m_s1;
            r_s_side <= r_m_side;
        end
    end

    // plane descriptors: addresses and saturated totals
    always_comb begin
        logic base_nz;
        base_nz = (r_s_side.base != '0);

        n_f_plane0.stride = r_s_s0;
        n_f_plane0.rows   = r_s_side.rows0;
        n_f_plane0.addr   = r_s_side.base;
        n_f_plane0.total  = sat_total(OFF_W'(r_s_off1));

        n_f_plane1.stride = r_s_s1;
        n_f_plane1.rows   = r_s_side.rows1;
        n_f_plane1.addr   = base_nz ? (r_s_side.base + r_s_off1) : '0;
        n_f_plane1.total  = sat_total(OFF_W'(r_s_off2));

        n_f_plane2.stride = r_s_s1;
        n_f_plane2.rows   = r_s_side.rows1;
        n_f_plane2.addr   = base_nz ? (r_s_side.base + r_s_off2[ADDR_W-1:0]) : '0;
        n_f_plane2.total  = sat_total(r_s_off3);
    end

    // frame stage: holds one frame while its planes are handed out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_f_idx   <= '0;
        end else if (pipe_en) begin
            r_f_valid <= r_s_valid;
            r_f_idx   <= '0;
        end else if (f_give) begin
            r_f_idx   <= r_f_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_f_last_idx <= r_s_side.last_idx;
            r_f_err      <= r_s_side.err;
            r_f_plane0   <= n_f_plane0;
            r_f_plane1   <= n_f_plane1;
            r_f_plane2   <= n_f_plane2;
        end
    end

    // result select
    always_comb begin
        case (r_f_idx)
            IDX_W'(0): sel_plane = r_f_plane0;
            IDX_W'(1): sel_plane = r_f_plane1;
            default:   sel_plane = r_f_plane2;
        endcase

        if (r_f_err) begin
            n_o_data = '0;
            n_o_user = {1'b1, IDX_W'(0)};
        end else begin
            n_o_data = OUT_DATA_W'({sel_plane.total, sel_plane.addr,
                                    sel_plane.rows, sel_plane.stride});
            n_o_user = {1'b0, r_f_idx};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_give) begin
            r_o_data <= n_o_data;
            r_o_user <= n_o_user;
            r_o_last <= f_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_user;
    assign m_axis_tlast  = r_o_last;

    // an error result stands alone with all fields cleared
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[IDX_W]) |->
            (m_axis_tlast && (m_axis_tdata == '0) && (m_axis_tuser[IDX_W-1:0] == '0)))
        else $error("error result not isolated");

    // plane counter never passes the frame's final plane
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_valid |-> (r_f_idx <= r_f_last_idx))
        else $error("plane counter out of range");

    // a taken non-final plane is followed at once by the next one
    a_next_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("frame planes not contiguous");

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import fpl_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LEN   = DIV_LAT + 5 + 20;
    localparam int N_DIRECTED  = 25;
    localparam int N_PHASES    = 7;
    localparam longint unsigned FRAME_SAT = 64'h7FFF_FFFF;

    // one expected plane result
    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [NUM_W-1:0]  stride;
        logic [ROWS_W-1:0] rows;
        logic [ADDR_W-1:0] addr;
        logic [TOT_W-1:0]  total;
        logic              last;
        logic              err;
    } t_plane_exp;

    // one row of the directed table; known rows carry their single result
    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        t_fmt              fmt;
        logic [ADDR_W-1:0] base;
        logic              known;
        logic [NUM_W-1:0]  stride;
        logic [ROWS_W-1:0] rows;
        logic [ADDR_W-1:0] addr;
        logic [TOT_W-1:0]  total;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wen = 1'b0;
    logic [ALIGN_W-1:0]    i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    t_plane_exp   plane_queue[$];
    t_stim_row    directed_rows [N_DIRECTED];
    logic [ALIGN_W-1:0] stride_align = 13'd1;
    int           send_idle_pct = 14;
    int           recv_idle_pct = 57;
    int           mismatch_count = 0;
    int           request_count = 0;
    int           result_count = 0;
    int           cycle_count = 0;

    frame_plane_layout_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // plane layout of one frame request, queued in plane order
    function automatic void predict_planes(input logic [DIM_W-1:0] width,
                                           input logic [DIM_W-1:0] height,
                                           input t_fmt fmt,
                                           input logic [ADDR_W-1:0] base);
        longint unsigned w, h, we, he, a, s, off, tot;
        longint unsigned st [4];
        longint unsigned rw [4];
        int n;
        t_plane_exp p;
        w = width;
        h = height;
        we = (w + 1) & 64'hFFFF_FFFF_FFFF_FFFE;
        he = (h + 1) & 64'hFFFF_FFFF_FFFF_FFFE;
        for (int i = 0; i < 4; i++) begin
            st[i] = 0;
            rw[i] = 0;
        end
        n = 0;
        case (fmt)
            FMT_YUV420P, FMT_YUV420P_HI: begin
                st[0] = we; st[1] = we / 2; st[2] = we / 2;
                rw[0] = he; rw[1] = he / 2; rw[2] = he / 2;
                n = 3;
            end
            FMT_YUV422P, FMT_YUV422P_HI: begin
                st[0] = we; st[1] = we / 2; st[2] = we / 2;
                rw[0] = h; rw[1] = h; rw[2] = h;
                n = 3;
            end
            FMT_YUV444P, FMT_YUV444P_HI: begin
                st[0] = w; st[1] = w; st[2] = w;
                rw[0] = h; rw[1] = h; rw[2] = h;
                n = 3;
            end
            FMT_NV12: begin
                st[0] = we; st[1] = we; rw[0] = he; rw[1] = he / 2; n = 2;
            end
            FMT_P016: begin
                st[0] = we * 2; st[1] = we * 2; rw[0] = he; rw[1] = he / 2; n = 2;
            end
            FMT_NV16: begin
                st[0] = we; st[1] = we; rw[0] = he; rw[1] = he; n = 2;
            end
            FMT_NV24: begin
                st[0] = we; st[1] = we * 2; rw[0] = he; rw[1] = he; n = 2;
            end
            FMT_GRAY8:   begin st[0] = w;     rw[0] = h; n = 1; end
            FMT_GRAY16:  begin st[0] = w * 2; rw[0] = h; n = 1; end
            FMT_GRAYF32: begin st[0] = w * 4; rw[0] = h; n = 1; end
            FMT_RGB24:   begin st[0] = w * 3; rw[0] = h; n = 1; end
            FMT_RGB32:   begin st[0] = w * 4; rw[0] = h; n = 1; end
            default: n = 0;
        endcase
        // unsupported class: a lone error result
        if (n == 0) begin
            p = '{idx: '0, stride: '0, rows: '0, addr: '0, total: '0, last: 1'b1, err: 1'b1};
            plane_queue.push_back(p);
            return;
        end
        // two bytes per sample on the planar hi formats
        if (fmt == FMT_YUV420P_HI || fmt == FMT_YUV422P_HI || fmt == FMT_YUV444P_HI) begin
            for (int i = 0; i < 3; i++) st[i] = st[i] * 2;
        end
        a = (stride_align == '0) ? 1 : stride_align;
        off = 0;
        for (int i = 0; i < n; i++) begin
            s = ((st[i] + a - 1) / a) * a;
            p.idx    = IDX_W'(i);
            p.stride = NUM_W'(s);
            p.rows   = ROWS_W'(rw[i]);
            p.addr   = (base == '0) ? '0 : ADDR_W'(base + off);
            off      = off + s * rw[i];
            tot      = (off > FRAME_SAT) ? FRAME_SAT : off;
            p.total  = TOT_W'(tot);
            p.last   = (i == n - 1);
            p.err    = 1'b0;
            plane_queue.push_back(p);
        end
    endfunction

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin : result_check
        t_plane_exp want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_count++;
            if (plane_queue.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none actual data %0h user %0h",
                         $time, m_axis_tdata, m_axis_tuser);
            end else begin
                want = plane_queue.pop_front();
                compare_field("plane_index", want.idx, m_axis_tuser[1:0]);
                compare_field("line_stride", want.stride, m_axis_tdata[16:0]);
                compare_field("plane_rows", want.rows, m_axis_tdata[31:17]);
                compare_field("plane_address", want.addr, m_axis_tdata[63:32]);
                compare_field("frame_bytes", want.total, m_axis_tdata[94:64]);
                compare_field("last_plane", want.last, m_axis_tlast);
                compare_field("format_error", want.err, m_axis_tuser[2]);
            end
        end
    end

    // offer one frame request and queue its planes once it is taken
    task automatic send_request(input logic [DIM_W-1:0] width, input logic [DIM_W-1:0] height,
                                input t_fmt fmt, input logic [ADDR_W-1:0] base,
                                input logic known, input t_plane_exp known_res);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, base, height, width};
        s_axis_tuser  <= fmt;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        request_count++;
        if (known) plane_queue.push_back(known_res);
        else predict_planes(width, height, fmt, base);
    endtask

    task automatic wait_idle();
        while (plane_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_align(input logic [ALIGN_W-1:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        stride_align = value;
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return DIM_W'($urandom_range(0, 40));
            4, 5, 6:    return DIM_W'($urandom);
            7:          return '1;
            8:          return DIM_W'(1);
            default:    return DIM_W'($urandom_range(0, 1) ? 16382 : 0);
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_base();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    // stimulus
    initial begin : stimulus
        logic [ALIGN_W-1:0] align_plan [N_PHASES];
        int send_plan [N_PHASES];
        int recv_plan [N_PHASES];
        int count_plan [N_PHASES];
        t_plane_exp kr;
        t_stim_row  row;
        t_plane_exp none;

        // directed table at the reset alignment of 1
        directed_rows[0]  = '{1, 1, FMT_GRAY8, 0, 1, 1, 1, 0, 1};
        directed_rows[1]  = '{16383, 16383, FMT_GRAY8, 32'hFFFF_FFFF, 1,
                              16383, 16383, 32'hFFFF_FFFF, 268402689};
        directed_rows[2]  = '{16383, 16383, FMT_BAD, 32'hFFFF_FFFF, 1, 0, 0, 0, 0};
        directed_rows[3]  = '{0, 0, FMT_BAD, 0, 1, 0, 0, 0, 0};
        directed_rows[4]  = '{0, 5, FMT_GRAY16, 32'h1000, 1, 0, 5, 32'h1000, 0};
        directed_rows[5]  = '{5, 0, FMT_RGB24, 32'h10, 1, 15, 0, 32'h10, 0};
        directed_rows[6]  = '{3, 2, FMT_RGB32, 32'h100, 1, 12, 2, 32'h100, 24};
        directed_rows[7]  = '{16383, 1, FMT_GRAYF32, 32'h8000_0000, 1,
                              65532, 1, 32'h8000_0000, 65532};
        directed_rows[8]  = '{7, 5, FMT_YUV420P, 32'h1000_0000, 0, 0, 0, 0, 0};
        directed_rows[9]  = '{7, 5, FMT_YUV420P_HI, 32'h2000, 0, 0, 0, 0, 0};
        directed_rows[10] = '{7, 5, FMT_YUV422P, 0, 0, 0, 0, 0, 0};
        directed_rows[11] = '{7, 5, FMT_YUV422P_HI, 32'h44, 0, 0, 0, 0, 0};
        directed_rows[12] = '{7, 5, FMT_YUV444P, 32'h10000, 0, 0, 0, 0, 0};
        directed_rows[13] = '{7, 5, FMT_YUV444P_HI, 32'hFFFF_FF00, 0, 0, 0, 0, 0};
        directed_rows[14] = '{7, 5, FMT_NV12, 32'h3000, 0, 0, 0, 0, 0};
        directed_rows[15] = '{7, 5, FMT_P016, 32'h4000, 0, 0, 0, 0, 0};
        directed_rows[16] = '{7, 5, FMT_NV16, 32'h5000, 0, 0, 0, 0, 0};
        directed_rows[17] = '{7, 5, FMT_NV24, 32'h6000, 0, 0, 0, 0, 0};
        // full-size frames; the first two wrap plane addresses past the top of the address space
        directed_rows[18] = '{16383, 16383, FMT_YUV420P, 32'hFFFF_FFF0, 0, 0, 0, 0, 0};
        directed_rows[19] = '{16383, 16383, FMT_NV24, 32'hF000_0000, 0, 0, 0, 0, 0};
        directed_rows[20] = '{16383, 16383, FMT_YUV444P_HI, 1, 0, 0, 0, 0, 0};
        // zero dimensions still give the full plane count
        directed_rows[21] = '{0, 0, FMT_P016, 32'hABCD, 0, 0, 0, 0, 0};
        directed_rows[22] = '{1, 1, FMT_YUV422P, 32'hFFFF_FFFF, 0, 0, 0, 0, 0};
        directed_rows[23] = '{16383, 1, FMT_NV12, 32'h7FFF_FFFF, 0, 0, 0, 0, 0};
        directed_rows[24] = '{16382, 16382, FMT_YUV420P_HI, 32'hC000_0000, 0, 0, 0, 0, 0};

        // random phases: alignment, sender idle, receiver idle, request count
        align_plan = '{13'd0, 13'd8191, 13'd4096, 13'($urandom_range(1, 4096)), 13'd3,
                       13'($urandom_range(1, 4096)), 13'd1};
        send_plan  = '{14, 14, 57, 57, 0, 0, 0};
        recv_plan  = '{57, 57, 14, 14, 0, 0, 0};
        count_plan = '{30, 30, 30, 30, 30, 30, 20};
        none = '{idx: '0, stride: '0, rows: '0, addr: '0, total: '0, last: 1'b0, err: 1'b0};

        // reset
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        send_idle_pct = 14;
        recv_idle_pct = 57;
        for (int i = 0; i < N_DIRECTED; i++) begin
            row = directed_rows[i];
            kr = '{idx: '0, stride: row.stride, rows: row.rows, addr: row.addr,
                   total: row.total, last: 1'b1, err: (row.fmt == FMT_BAD)};
            send_request(row.width, row.height, row.fmt, row.base, row.known, kr);
        end
        s_axis_tvalid <= 1'b0;

        // random part, alignment changed only with nothing in flight
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            write_align(align_plan[ph]);
            send_idle_pct = send_plan[ph];
            recv_idle_pct = recv_plan[ph];
            for (int i = 0; i < count_plan[ph]; i++) begin
                send_request(pick_dim(), pick_dim(), t_fmt'($urandom_range(0, 15)),
                             pick_base(), 1'b0, none);
            end
            s_axis_tvalid <= 1'b0;
        end

        // drain and watch for stray results
        wait_idle();
        repeat (DRAIN_LEN) @(posedge i_clk);
        if (plane_queue.size() != 0) begin
            mismatch_count += plane_queue.size();
            $display("%0t: %0d expected results never arrived", $time, plane_queue.size());
        end
        $display("covered %0d frame requests over all format classes and %0d alignment phases",
                 request_count, N_PHASES + 1);
        $display("checked %0d plane results with %0d mismatches", result_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
